@@ hw/rtl/cpr_pkg.sv @@
// ----------------------------------------------------------------------------
// cpr_pkg: shared types and constants of the cubic polyphase resampler
// Field widths, register indexes, MAC unit operations and the layout of
// one coefficient table entry.
// ----------------------------------------------------------------------------
package cpr_pkg;

  // fixed field widths
  localparam int unsigned COEF_BITS     = 18;
  localparam int unsigned COEF_FRAC     = 16;
  localparam int unsigned STEP_BITS     = 20;
  localparam int unsigned START_BITS    = 16;
  localparam int unsigned TPHASE_BITS   = 5;
  localparam int unsigned TAP_BITS      = 2;
  localparam int unsigned TAPS          = 4;

  // run and skip limits
  localparam int unsigned RUN_MAX       = 64;
  localparam int unsigned RUN_CNT_BITS  = 6;
  localparam int unsigned SKIP_BITS     = 4;
  localparam int unsigned SKIP_MAX      = 15;

  // configuration port
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 20;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_STEP        = 1'b0,
    CFG_START_PHASE = 1'b1
  } cpr_cfg_idx_e;

  // operations of the shared multiply/accumulate unit
  typedef enum logic [2:0] {
    MAC_NOP,
    MAC_MUL_DELTA,
    MAC_LOAD_W,
    MAC_MUL_SAMP,
    MAC_ACC_LOAD,
    MAC_ACC_ADD,
    MAC_ROUND
  } cpr_mac_op_e;

  // control from the sequencer to the MAC unit
  typedef struct packed {
    cpr_mac_op_e op;
  } cpr_mac_ctrl_t;

  // one coefficient table entry
  typedef struct packed {
    logic signed [COEF_BITS-1:0] coeff;
    logic signed [COEF_BITS-1:0] delta;
  } cpr_coef_t;

endpackage

@@ hw/rtl/cpr_coef_ram.sv @@
// ----------------------------------------------------------------------------
// cpr_coef_ram: coefficient table storage
// One write port and one read port, read data registered. Contents are
// undefined until written.
// ----------------------------------------------------------------------------
module cpr_coef_ram
  import cpr_pkg::*;
#(
  parameter int unsigned ADDR_W = 7
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  cpr_coef_t         wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output cpr_coef_t         rdata_o
);

  cpr_coef_t mem_q [2**ADDR_W];
  cpr_coef_t rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ hw/rtl/cpr_mac_unit.sv @@
// ----------------------------------------------------------------------------
// cpr_mac_unit: shared multiply/accumulate unit
// One multiplier serves both the weight interpolation (delta times the low
// phase bits) and the tap product (weight times sample). Also holds the
// accumulator and the final round and saturate step.
// ----------------------------------------------------------------------------
module cpr_mac_unit
  import cpr_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned PHASE_BITS  = 5,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned DiffBits   = FRAC_BITS - PHASE_BITS
) (
  input  logic                          clk_i,
  input  cpr_mac_ctrl_t                 ctrl_i,
  input  cpr_coef_t                     coef_i,
  input  logic [DiffBits-1:0]           frac_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  output logic signed [SAMPLE_BITS-1:0] y_o
);

  localparam int unsigned WgtW  = COEF_BITS + DiffBits + 1;
  localparam int unsigned MulBW = (SAMPLE_BITS > DiffBits + 1) ? SAMPLE_BITS : DiffBits + 1;
  localparam int unsigned ProdW = WgtW + MulBW;
  localparam int unsigned AccW  = WgtW + SAMPLE_BITS + 2;
  localparam int unsigned Shift = COEF_FRAC + DiffBits;
  localparam int unsigned RndW  = AccW + 1;
  localparam int unsigned ResW  = RndW - Shift;

  localparam logic signed [RndW-1:0] RndHalf = RndW'(1) << (Shift - 1);
  localparam logic signed [ResW-1:0] SatHi   = ResW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [ResW-1:0] SatLo   = ~SatHi;

  logic signed [WgtW-1:0]        mul_a;
  logic signed [MulBW-1:0]       mul_b;
  logic signed [ProdW-1:0]       prod_d, prod_q;
  logic signed [WgtW-1:0]        wgt_d, wgt_q;
  logic signed [AccW-1:0]        acc_q;
  logic signed [RndW-1:0]        rnd_sum;
  logic signed [ResW-1:0]        rnd_res;
  logic signed [SAMPLE_BITS-1:0] sat_d, y_q;

  // operand select for the shared multiplier
  always_comb begin
    mul_a = WgtW'(coef_i.delta);
    mul_b = MulBW'({1'b0, frac_i});
    if (ctrl_i.op == MAC_MUL_SAMP) begin
      mul_a = wgt_q;
      mul_b = MulBW'(sample_i);
    end
  end

  assign prod_d = mul_a * mul_b;

  // weight: coeff aligned to the interpolation fraction plus delta share
  assign wgt_d = (WgtW'(coef_i.coeff) <<< DiffBits) + WgtW'(prod_q);

  // round half up, then saturate
  assign rnd_sum = RndW'(acc_q) + RndHalf;
  assign rnd_res = ResW'(rnd_sum >>> Shift);

  always_comb begin
    if (rnd_res > SatHi) begin
      sat_d = SAMPLE_BITS'(SatHi);
    end else if (rnd_res < SatLo) begin
      sat_d = SAMPLE_BITS'(SatLo);
    end else begin
      sat_d = SAMPLE_BITS'(rnd_res);
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (ctrl_i.op)
      MAC_MUL_DELTA: prod_q <= prod_d;
      MAC_LOAD_W:    wgt_q  <= wgt_d;
      MAC_MUL_SAMP:  prod_q <= prod_d;
      MAC_ACC_LOAD:  acc_q  <= AccW'(prod_q);
      MAC_ACC_ADD:   acc_q  <= acc_q + AccW'(prod_q);
      MAC_ROUND:     y_q    <= sat_d;
      default: ;
    endcase
  end

  assign y_o = y_q;

endmodule

@@ hw/rtl/cubic_polyphase_resampler.sv @@
// Timing: a table write leaves the block idle; a sample item starts a run of n outputs,
// where n is 0 to 64, and the run waits in S_EMIT while the output is held.
// Each output takes five steps per tap on the one shared multiplier
// (read, delta product, weight, sample product, accumulate) plus round and emit.
// Throughput: one item at a time; input and config are not ready during a run.
// Reset: window, skip count, step and phase reset; the coefficient table does not.
// ----------------------------------------------------------------------------
// cubic_polyphase_resampler: four-tap cubic polyphase resampler
// Sample items shift a window; each output interpolates a coefficient row by
// the low phase bits and filters the window through a shared MAC unit.
// ----------------------------------------------------------------------------
module cubic_polyphase_resampler
  import cpr_pkg::*;
#(
  parameter int unsigned FRAC_BITS   = 16,
  parameter int unsigned PHASE_BITS  = 5,
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned InFieldW   = SAMPLE_BITS + TPHASE_BITS + TAP_BITS + 2 * COEF_BITS,
  localparam int unsigned InDataW    = ((InFieldW + 7) / 8) * 8,
  localparam int unsigned OutDataW   = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // configuration write channel
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  // input stream
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // tdata: sample, table_phase, table_tap, table_coeff, table_delta, zero pad
  input  logic [InDataW-1:0]       s_axis_tdata,
  // tuser: mode
  input  logic                     s_axis_tuser,
  // output stream
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // tdata: out_sample, zero pad
  output logic [OutDataW-1:0]      m_axis_tdata,
  // tlast: last
  output logic                     m_axis_tlast
);

  localparam int unsigned DiffBits = FRAC_BITS - PHASE_BITS;
  localparam int unsigned AddrW    = PHASE_BITS + TAP_BITS;
  localparam int unsigned SumW     = ((FRAC_BITS > STEP_BITS) ? FRAC_BITS : STEP_BITS) + 1;
  localparam int unsigned CarryW   = SumW - FRAC_BITS;
  localparam int unsigned OffPhase = SAMPLE_BITS;
  localparam int unsigned OffTap   = OffPhase + TPHASE_BITS;
  localparam int unsigned OffCoeff = OffTap + TAP_BITS;
  localparam int unsigned OffDelta = OffCoeff + COEF_BITS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_MULD,
    S_WGT,
    S_MULS,
    S_ACC,
    S_RND,
    S_EMIT
  } state_e;

  state_e                         state_q;
  logic [TAP_BITS-1:0]            tap_q;
  logic [RUN_CNT_BITS-1:0]        run_cnt_q;
  logic [SKIP_BITS-1:0]           skip_q;
  logic [FRAC_BITS-1:0]           phase_q;
  logic [STEP_BITS-1:0]           step_q;
  logic signed [SAMPLE_BITS-1:0]  window_q [TAPS];
  logic                           out_valid_q;
  logic [SAMPLE_BITS-1:0]         out_data_q;
  logic                           out_last_q;

  logic                           in_accept;
  logic                           out_free;
  logic                           emit_fire;
  logic [SumW-1:0]                phase_sum;
  logic [CarryW-1:0]              carry;
  logic [SKIP_BITS-1:0]           skip_sat;
  logic                           run_end;
  cpr_mac_ctrl_t                  mac_ctrl;
  cpr_coef_t                      ram_wdata;
  cpr_coef_t                      ram_rdata;
  logic [AddrW-1:0]               ram_waddr;
  logic [AddrW-1:0]               ram_raddr;
  logic signed [SAMPLE_BITS-1:0]  mac_y;

  // input field unpacking
  logic signed [SAMPLE_BITS-1:0]  in_sample;
  logic [TPHASE_BITS-1:0]         in_tphase;
  logic [TAP_BITS-1:0]            in_ttap;

  assign in_sample       = s_axis_tdata[SAMPLE_BITS-1:0];
  assign in_tphase       = s_axis_tdata[OffPhase +: TPHASE_BITS];
  assign in_ttap         = s_axis_tdata[OffTap +: TAP_BITS];
  assign ram_wdata.coeff = s_axis_tdata[OffCoeff +: COEF_BITS];
  assign ram_wdata.delta = s_axis_tdata[OffDelta +: COEF_BITS];

  // handshakes
  assign s_axis_tready = (state_q == S_IDLE);
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign emit_fire     = (state_q == S_EMIT) && out_free;
  assign cfg_ready_o   = (state_q == S_IDLE);

  // phase advance and carry into skipped inputs
  assign phase_sum = SumW'(phase_q) + SumW'(step_q);
  assign carry     = phase_sum[SumW-1:FRAC_BITS];
  assign skip_sat  = (32'(carry) > SKIP_MAX) ? SKIP_BITS'(SKIP_MAX) : SKIP_BITS'(carry);
  assign run_end   = (run_cnt_q == RUN_CNT_BITS'(RUN_MAX - 1));

  // coefficient table ports
  assign ram_waddr = {PHASE_BITS'(in_tphase), in_ttap};
  assign ram_raddr = {phase_q[FRAC_BITS-1:DiffBits], tap_q};

  cpr_coef_ram #(
    .ADDR_W (AddrW)
  ) u_coef_ram (
    .clk_i   (clk_i),
    .we_i    (in_accept && s_axis_tuser),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // MAC operation per sequencer step
  always_comb begin
    mac_ctrl.op = MAC_NOP;
    unique case (state_q)
      S_MULD: mac_ctrl.op = MAC_MUL_DELTA;
      S_WGT:  mac_ctrl.op = MAC_LOAD_W;
      S_MULS: mac_ctrl.op = MAC_MUL_SAMP;
      S_ACC:  mac_ctrl.op = (tap_q == '0) ? MAC_ACC_LOAD : MAC_ACC_ADD;
      S_RND:  mac_ctrl.op = MAC_ROUND;
      S_IDLE, S_READ, S_EMIT: mac_ctrl.op = MAC_NOP;
    endcase
  end

  cpr_mac_unit #(
    .FRAC_BITS   (FRAC_BITS),
    .PHASE_BITS  (PHASE_BITS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_mac_unit (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .coef_i   (ram_rdata),
    .frac_i   (phase_q[DiffBits-1:0]),
    .sample_i (window_q[tap_q]),
    .y_o      (mac_y)
  );

  // sequencer, state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      tap_q       <= '0;
      run_cnt_q   <= '0;
      skip_q      <= '0;
      phase_q     <= '0;
      step_q      <= STEP_BITS'(65536);
      window_q    <= '{default: '0};
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      out_last_q  <= 1'b0;
    end else begin
      // output register valid
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end

      // configuration transaction
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cpr_cfg_idx_e'(cfg_index_i))
          CFG_STEP:        step_q  <= cfg_data_i[STEP_BITS-1:0];
          CFG_START_PHASE: phase_q <= FRAC_BITS'(cfg_data_i[START_BITS-1:0]);
        endcase
      end

      unique case (state_q)
        S_IDLE: begin
          if (in_accept && !s_axis_tuser) begin
            for (int i = 0; i < TAPS - 1; i++) begin
              window_q[i] <= window_q[i+1];
            end
            window_q[TAPS-1] <= in_sample;
            if (skip_q > SKIP_BITS'(1)) begin
              skip_q <= skip_q - SKIP_BITS'(1);
            end else begin
              skip_q    <= '0;
              run_cnt_q <= '0;
              tap_q     <= '0;
              state_q   <= S_READ;
            end
          end
        end
        S_READ: state_q <= S_MULD;
        S_MULD: state_q <= S_WGT;
        S_WGT:  state_q <= S_MULS;
        S_MULS: state_q <= S_ACC;
        S_ACC: begin
          if (tap_q == TAP_BITS'(TAPS - 1)) begin
            state_q <= S_RND;
          end else begin
            tap_q   <= tap_q + TAP_BITS'(1);
            state_q <= S_READ;
          end
        end
        S_RND: state_q <= S_EMIT;
        S_EMIT: begin
          if (out_free) begin
            out_data_q  <= mac_y;
            out_last_q  <= (carry != '0) || run_end;
            phase_q     <= phase_sum[FRAC_BITS-1:0];
            if (carry != '0) begin
              skip_q  <= skip_sat;
              state_q <= S_IDLE;
            end else if (run_end) begin
              state_q <= S_IDLE;
            end else begin
              run_cnt_q <= run_cnt_q + RUN_CNT_BITS'(1);
              tap_q     <= '0;
              state_q   <= S_READ;
            end
          end
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OutDataW'(out_data_q);
  assign m_axis_tlast  = out_last_q;

endmodule

@@ hw/rtl/cpr_checker.sv @@
// ----------------------------------------------------------------------------
// cpr_checker: port-level checks for the cubic polyphase resampler
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module cpr_checker #(
  parameter int unsigned SAMPLE_BITS = 16,
  localparam int unsigned OutDataW   = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                s_axis_tuser,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic                m_axis_tlast
);

  // a stalled result stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output valid dropped while stalled");

  // a stalled result keeps its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output payload changed while stalled");

  // a table write leaves the block ready and causes no result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> s_axis_tready && !$rose(m_axis_tvalid))
    else $error("table write started a run");

  // a new result only appears from inside a run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
    else $error("result produced while idle");

endmodule

bind cubic_polyphase_resampler cpr_checker #(
  .SAMPLE_BITS (SAMPLE_BITS)
) u_cpr_checker (.*);
